// File: hw/rtl/bwws_pkg.sv
// ----------------------------------------------------------------------------
// bwws_pkg: shared types and constants for the weighted window smoother
// Holds the field codes, register indexes, default sizes and the control
// struct that moves down the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

package bwws_pkg;

  // default sizes for the top level parameters
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_RADIUS_DEF  = 3;
  localparam int WEIGHT_BITS_DEF = 16;

  // fixed field widths
  localparam int NUM_CH     = 3;
  localparam int CH_W       = 8;
  localparam int QUO_W      = 8;
  localparam int ROW_W      = 12;
  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DRAIN = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

  // control that travels with each division through the cell chain
  typedef struct packed {
    logic vld;
    logic zero;
    logic last;
  } div_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/bwws_div_cell.sv
// ----------------------------------------------------------------------------
// bwws_div_cell: one restoring division step for all three channels
// Decides one quotient bit per cell and passes remainder, divisor and
// partial quotients to the next cell on every clock.
// ----------------------------------------------------------------------------
`default_nettype none

module bwws_div_cell import bwws_pkg::*; #(
  parameter int ACC_W = 30,
  parameter int DIV_W = 22,
  parameter int SHIFT = 7
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire div_ctl_t                          ctl_i,
  input  wire logic [NUM_CH-1:0][ACC_W-1:0]      rem_i,
  input  wire logic [DIV_W-1:0]                  div_i,
  input  wire logic [NUM_CH-1:0][QUO_W-1:0]      quo_i,
  output div_ctl_t                               ctl_o,
  output logic      [NUM_CH-1:0][ACC_W-1:0]      rem_o,
  output logic      [DIV_W-1:0]                  div_o,
  output logic      [NUM_CH-1:0][QUO_W-1:0]      quo_o
);

  div_ctl_t                         ctl_r;
  logic [NUM_CH-1:0][ACC_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]                 div_r;
  logic [NUM_CH-1:0][QUO_W-1:0]     quo_r, quo_nxt;
  logic [ACC_W-1:0]                 trial;

  // compare against the shifted divisor and subtract where it fits
  always_comb begin
    trial   = ACC_W'(div_i) << SHIFT;
    rem_nxt = rem_i;
    quo_nxt = quo_i;
    for (int c = 0; c < NUM_CH; c++) begin
      if (rem_i[c] >= trial) begin
        rem_nxt[c]        = rem_i[c] - trial;
        quo_nxt[c][SHIFT] = 1'b1;
      end
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    div_r <= div_i;
    quo_r <= quo_nxt;
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign div_o = div_r;
  assign quo_o = quo_r;

endmodule

`default_nettype wire

// File: hw/rtl/bgr_weighted_window_smoother.sv
// ----------------------------------------------------------------------------
// bgr_weighted_window_smoother: renormalized weighted window filter, BGR888
// Stores recent rows, sums weight * sample over the window taps inside the
// frame and divides by the weight total through a chain of divider cells.
// ----------------------------------------------------------------------------
// A pixel or drain beat that yields a result starts a scan of the window taps
// on the row store read port, then passes through 2 product/sum stages and 8
// divider cells to the output register. A beat with no result starts no scan.
// The next beat is taken while a result still waits on the output. Reset
// clears counters and weight valid bits (the weights read as zero); the row
// store is not cleared and needs no sweep.
`default_nettype none

module bgr_weighted_window_smoother import bwws_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: weight_index[5:0], weight_value[21:6], in_blue[29:22],
  // in_green[37:30], in_red[45:38], zero fill [47:46]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: kind[1:0]
  input  wire logic [KIND_W-1:0]     in_tuser,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // out_tdata: out_blue[7:0], out_green[15:8], out_red[23:16]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SPAN   = 2 * MAX_RADIUS + 1;
  localparam int TAPS   = SPAN * SPAN;
  localparam int TAP_W  = $clog2(TAPS);
  localparam int SPAN_W = $clog2(SPAN);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int LIN_W  = ROW_W + COL_W;
  localparam int DEPTH  = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WSUM_W = WEIGHT_BITS + $clog2(TAPS + 1);
  localparam int ACC_W  = WSUM_W + QUO_W;
  localparam int PROD_W = WEIGHT_BITS + CH_W;
  localparam int PIX_W  = NUM_CH * CH_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_PARK  = 4'b1000
  } state_t;

  // ---------------- configuration ----------------
  logic [10:0]      cfg_w_r;
  logic [ROW_W-1:0] cfg_h_r;
  logic [1:0]       cfg_rad_r;
  logic             cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r   <= 11'd1024;
      cfg_h_r   <= 12'd1024;
      cfg_rad_r <= 2'd1;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:   cfg_w_r   <= cfg_data[10:0];
        REG_FRAME_HEIGHT:  cfg_h_r   <= cfg_data[ROW_W-1:0];
        REG_WINDOW_RADIUS: cfg_rad_r <= cfg_data[1:0];
        default:           ;
      endcase
    end
  end

  // effective frame size and radius
  logic [COL_W-1:0]  eff_w;
  logic [ROW_W-1:0]  eff_h;
  logic [RAD_W-1:0]  eff_r;
  logic [SPAN_W-1:0] len_m1;

  always_comb begin
    if (cfg_w_r == '0) begin
      eff_w = COL_W'(1);
    end else if (32'(cfg_w_r) > MAX_WIDTH) begin
      eff_w = COL_W'(MAX_WIDTH);
    end else begin
      eff_w = COL_W'(cfg_w_r);
    end
    eff_h  = (cfg_h_r == '0) ? ROW_W'(1) : cfg_h_r;
    eff_r  = (32'(cfg_rad_r) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(cfg_rad_r);
    len_m1 = SPAN_W'({eff_r, 1'b0});
  end

  // ---------------- position counters ----------------
  state_t            state_r, state_nxt;
  logic              stale_r;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt, out_addr_r, out_addr_nxt;
  logic [LIN_W-1:0]  in_base_r, out_base_r, rw_r;

  // products of rows and width, registered from the counters
  always_ff @(posedge clk) begin
    in_base_r  <= LIN_W'(in_row_r) * LIN_W'(eff_w);
    out_base_r <= LIN_W'(out_row_r) * LIN_W'(eff_w);
    rw_r       <= LIN_W'(eff_r) * LIN_W'(eff_w);
  end

  logic              in_fire;
  logic [KIND_W-1:0] kind;
  logic [5:0]        w_idx;
  logic              pix_ok, col_wrap, oc_wrap, pix_emit, drain_emit, emit, last;
  logic [LIN_W:0]    in_lin_p, out_lin_ext;
  logic [ROW_W-1:0]  out_row_p;
  logic [ADDR_W:0]   start_diff;
  logic [ADDR_W-1:0] start_addr;

  assign in_tready = (state_r == ST_IDLE) && !stale_r;
  assign in_fire   = in_tvalid && in_tready;
  assign kind      = in_tuser;
  assign w_idx     = in_tdata[5:0];

  // accept decisions
  always_comb begin
    pix_ok   = (kind == KIND_PIXEL) && (in_row_r < eff_h);
    col_wrap = ({1'b0, in_col_r} + 1'b1) >= {1'b0, eff_w};
    in_lin_p = col_wrap ? (LIN_W+1)'(in_base_r) + (LIN_W+1)'(eff_w)
                        : (LIN_W+1)'(in_base_r) + (LIN_W+1)'(in_col_r) + 1'b1;
    out_lin_ext = (LIN_W+1)'(out_base_r) + (LIN_W+1)'(out_col_r)
                + (LIN_W+1)'(rw_r) + (LIN_W+1)'(eff_r);
    pix_emit   = pix_ok && (out_lin_ext < in_lin_p);
    drain_emit = (kind == KIND_DRAIN) && (in_row_r >= eff_h);
    emit       = pix_emit || drain_emit;
    oc_wrap    = ({1'b0, out_col_r} + 1'b1) >= {1'b0, eff_w};
    out_row_p  = oc_wrap ? out_row_r + 1'b1 : out_row_r;
    last       = out_row_p >= eff_h;
    start_diff = (ADDR_W+1)'(out_addr_r) - (ADDR_W+1)'(rw_r + LIN_W'(eff_r));
    start_addr = start_diff[ADDR_W] ? ADDR_W'(start_diff + (ADDR_W+1)'(DEPTH))
                                    : ADDR_W'(start_diff);
  end

  // counter next values
  always_comb begin
    in_row_nxt   = in_row_r;
    in_col_nxt   = in_col_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    wr_addr_nxt  = wr_addr_r;
    out_addr_nxt = out_addr_r;
    if (in_fire && pix_ok) begin
      in_row_nxt  = col_wrap ? in_row_r + 1'b1 : in_row_r;
      in_col_nxt  = col_wrap ? '0 : in_col_r + 1'b1;
      wr_addr_nxt = (32'(wr_addr_r) == DEPTH - 1) ? '0 : wr_addr_r + 1'b1;
    end
    if (in_fire && emit) begin
      out_row_nxt  = out_row_p;
      out_col_nxt  = oc_wrap ? '0 : out_col_r + 1'b1;
      out_addr_nxt = (32'(out_addr_r) == DEPTH - 1) ? '0 : out_addr_r + 1'b1;
      if (last) begin
        in_row_nxt   = '0;
        in_col_nxt   = '0;
        out_row_nxt  = '0;
        out_col_nxt  = '0;
        wr_addr_nxt  = '0;
        out_addr_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      wr_addr_r  <= '0;
      out_addr_r <= '0;
      stale_r    <= 1'b0;
    end else begin
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      wr_addr_r  <= wr_addr_nxt;
      out_addr_r <= out_addr_nxt;
      stale_r    <= in_fire || cfg_fire;
    end
  end

  // ---------------- memories ----------------
  logic [PIX_W-1:0]       row_mem [DEPTH];
  logic [WEIGHT_BITS-1:0] wt_mem  [TAPS];
  logic [TAPS-1:0]        wv_r;
  logic [PIX_W-1:0]       px_q_r;
  logic [WEIGHT_BITS-1:0] wt_q_r;
  logic                   wv_q_r;
  logic [ADDR_W-1:0]      col_addr_r, col_addr_nxt, row_addr_r, row_addr_nxt;
  logic [TAP_W-1:0]       tap_r, tap_nxt;
  logic                   wt_load;

  assign wt_load = in_fire && (kind == KIND_LOAD) && (32'(w_idx) < TAPS);

  // row store: pixel write on accept, tap read during scan
  always_ff @(posedge clk) begin
    if (in_fire && pix_ok) begin
      row_mem[wr_addr_r] <= in_tdata[29+16:22];
    end
    px_q_r <= row_mem[col_addr_r];
  end

  // weight table
  always_ff @(posedge clk) begin
    if (wt_load) begin
      wt_mem[TAP_W'(w_idx)] <= WEIGHT_BITS'(in_tdata[21:6]);
    end
    wt_q_r <= wt_mem[tap_r];
    wv_q_r <= wv_r[tap_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r <= '0;
    end else if (wt_load) begin
      wv_r[TAP_W'(w_idx)] <= 1'b1;
    end
  end

  // ---------------- window scan sequencer ----------------
  logic [ROW_W-1:0]  snap_row_r;
  logic [COL_W-1:0]  snap_col_r;
  logic              snap_last_r;
  logic [SPAN_W-1:0] dy_r, dy_nxt, dx_r, dx_nxt;
  logic [ROW_W:0]    row_pos;
  logic [COL_W:0]    col_pos;
  logic              tap_use, scan_end;
  logic [ADDR_W:0]   row_step, col_step;

  always_comb begin
    row_pos  = (ROW_W+1)'(snap_row_r) + (ROW_W+1)'(dy_r);
    col_pos  = (COL_W+1)'(snap_col_r) + (COL_W+1)'(dx_r);
    tap_use  = (row_pos >= (ROW_W+1)'(eff_r))
            && ((row_pos - (ROW_W+1)'(eff_r)) < (ROW_W+1)'(eff_h))
            && (col_pos >= (COL_W+1)'(eff_r))
            && ((col_pos - (COL_W+1)'(eff_r)) < (COL_W+1)'(eff_w));
    scan_end = (dy_r == len_m1) && (dx_r == len_m1);
    row_step = (ADDR_W+1)'(row_addr_r) + (ADDR_W+1)'(eff_w);
    col_step = (ADDR_W+1)'(col_addr_r) + 1'b1;
  end

  always_comb begin
    dy_nxt       = dy_r;
    dx_nxt       = dx_r;
    tap_nxt      = tap_r;
    row_addr_nxt = row_addr_r;
    col_addr_nxt = col_addr_r;
    if (in_fire && emit) begin
      dy_nxt       = '0;
      dx_nxt       = '0;
      tap_nxt      = '0;
      row_addr_nxt = start_addr;
      col_addr_nxt = start_addr;
    end else if (state_r == ST_SCAN) begin
      tap_nxt = tap_r + 1'b1;
      if (dx_r == len_m1) begin
        dx_nxt       = '0;
        dy_nxt       = dy_r + 1'b1;
        row_addr_nxt = (row_step >= (ADDR_W+1)'(DEPTH))
                     ? ADDR_W'(row_step - (ADDR_W+1)'(DEPTH)) : ADDR_W'(row_step);
        col_addr_nxt = row_addr_nxt;
      end else begin
        dx_nxt       = dx_r + 1'b1;
        col_addr_nxt = (col_step >= (ADDR_W+1)'(DEPTH))
                     ? ADDR_W'(col_step - (ADDR_W+1)'(DEPTH)) : ADDR_W'(col_step);
      end
    end
  end

  always_ff @(posedge clk) begin
    dy_r       <= dy_nxt;
    dx_r       <= dx_nxt;
    tap_r      <= tap_nxt;
    row_addr_r <= row_addr_nxt;
    col_addr_r <= col_addr_nxt;
    if (in_fire && emit) begin
      snap_row_r  <= out_row_r;
      snap_col_r  <= out_col_r;
      snap_last_r <= last;
    end
  end

  // ---------------- product and sum stages ----------------
  logic                               s1_act_r, s1_use_r, s1_end_r;
  logic                               s2_act_r, s2_end_r;
  logic [NUM_CH-1:0][PROD_W-1:0]      prod_r;
  logic [WEIGHT_BITS-1:0]             wt_used, wt2_r;
  logic [NUM_CH-1:0][ACC_W-1:0]       acc_r, acc_sum;
  logic [WSUM_W-1:0]                  wsum_r, wsum_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_act_r <= 1'b0;
      s1_end_r <= 1'b0;
      s2_act_r <= 1'b0;
      s2_end_r <= 1'b0;
    end else begin
      s1_act_r <= (state_r == ST_SCAN);
      s1_end_r <= (state_r == ST_SCAN) && scan_end;
      s2_act_r <= s1_act_r;
      s2_end_r <= s1_end_r;
    end
  end

  assign wt_used = (s1_use_r && wv_q_r) ? wt_q_r : '0;

  // tap weighting, one multiplier per channel
  always_ff @(posedge clk) begin
    s1_use_r <= tap_use;
    wt2_r    <= wt_used;
    for (int c = 0; c < NUM_CH; c++) begin
      prod_r[c] <= PROD_W'(px_q_r[c*CH_W +: CH_W]) * PROD_W'(wt_used);
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      acc_sum[c] = acc_r[c] + ACC_W'(prod_r[c]);
    end
    wsum_sum = wsum_r + WSUM_W'(wt2_r);
  end

  // window accumulators, cleared when a sum leaves for the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      wsum_r <= '0;
    end else if (s2_act_r) begin
      acc_r  <= s2_end_r ? '0 : acc_sum;
      wsum_r <= s2_end_r ? '0 : wsum_sum;
    end
  end

  // ---------------- divider cell chain ----------------
  div_ctl_t                       chain_ctl [QUO_W+1];
  logic [NUM_CH-1:0][ACC_W-1:0]   chain_rem [QUO_W+1];
  logic [WSUM_W-1:0]              chain_div [QUO_W+1];
  logic [NUM_CH-1:0][QUO_W-1:0]   chain_quo [QUO_W+1];

  always_comb begin
    chain_ctl[0].vld  = s2_act_r && s2_end_r;
    chain_ctl[0].zero = (wsum_sum == '0);
    chain_ctl[0].last = snap_last_r;
  end
  assign chain_rem[0] = acc_sum;
  assign chain_div[0] = wsum_sum;
  assign chain_quo[0] = '0;

  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    bwws_div_cell #(
      .ACC_W (ACC_W),
      .DIV_W (WSUM_W),
      .SHIFT (QUO_W - 1 - k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (chain_ctl[k]),
      .rem_i (chain_rem[k]),
      .div_i (chain_div[k]),
      .quo_i (chain_quo[k]),
      .ctl_o (chain_ctl[k+1]),
      .rem_o (chain_rem[k+1]),
      .div_o (chain_div[k+1]),
      .quo_o (chain_quo[k+1])
    );
  end

  // ---------------- result and output register ----------------
  logic [OUT_DATA_W-1:0] res_data;
  logic [OUT_DATA_W-1:0] park_data_r, out_data_r;
  logic                  park_last_r, out_last_r, out_vld_r;
  logic                  slot_free, tail_vld, load_tail, load_park;

  assign res_data  = chain_ctl[QUO_W].zero ? '0 : OUT_DATA_W'(chain_quo[QUO_W]);
  assign tail_vld  = chain_ctl[QUO_W].vld;
  assign slot_free = !out_vld_r || out_tready;
  assign load_tail = (state_r == ST_FLUSH) && tail_vld && slot_free;
  assign load_park = (state_r == ST_PARK) && slot_free;

  always_ff @(posedge clk) begin
    if ((state_r == ST_FLUSH) && tail_vld) begin
      park_data_r <= res_data;
      park_last_r <= chain_ctl[QUO_W].last;
    end
    if (load_tail) begin
      out_data_r <= res_data;
      out_last_r <= chain_ctl[QUO_W].last;
    end else if (load_park) begin
      out_data_r <= park_data_r;
      out_last_r <= park_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_tail || load_park) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tvalid = out_vld_r;

  // ---------------- control state machine ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire && emit) state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_end) state_nxt = ST_FLUSH;
      ST_FLUSH: if (tail_vld) state_nxt = slot_free ? ST_IDLE : ST_PARK;
      ST_PARK:  if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- assertions ----------------
  a_tail_in_flush : assert property (@(posedge clk) disable iff (!rst_n)
    chain_ctl[QUO_W].vld |-> (state_r == ST_FLUSH))
    else $error("divider result arrived outside flush");

  a_settle_gap : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("beat accepted before counters settled");

  a_issue_from_scan : assert property (@(posedge clk) disable iff (!rst_n)
    s1_act_r |-> ($past(state_r) == ST_SCAN))
    else $error("tap read issued outside scan");

endmodule

`default_nettype wire
